/* rtl/asrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Age sorted record table package
// Command and status codes, record and response types shared by the block.
// ----------------------------------------------------------------------------
package asrt_pkg;

  typedef enum logic [1:0] {
    M_INSERT = 2'd0,
    M_REMOVE = 2'd1,
    M_SEARCH = 2'd2,
    M_RANGE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  age;
  } rec_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] rec_id;
    logic [7:0]  rec_age;
    logic [7:0]  min_age;
    logic [7:0]  max_age;
    logic [8:0]  age_span;
    logic [6:0]  entries;
    logic        last;
  } rsp_t;

  function automatic rsp_t mk_rsp(status_e st, logic [31:0] rid, logic [7:0] rage,
                                  logic [7:0] mn, logic [7:0] mx, logic [8:0] span,
                                  logic [6:0] cnt, logic lst);
    rsp_t r;
    r.status   = st;
    r.rec_id   = rid;
    r.rec_age  = rage;
    r.min_age  = mn;
    r.max_age  = mx;
    r.age_span = span;
    r.entries  = cnt;
    r.last     = lst;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/asrt_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface asrt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] id;
  logic [7:0]  age;

  modport source (output valid, output mode, output id, output age, input ready);
  modport sink   (input valid, input mode, input id, input age, output ready);
endinterface
`default_nettype wire

/* rtl/asrt_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface asrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] rec_id;
  logic [7:0]  rec_age;
  logic [7:0]  min_age;
  logic [7:0]  max_age;
  logic [8:0]  age_span;
  logic [6:0]  entries;
  logic        last;

  modport source (output valid, output status, output rec_id, output rec_age,
                  output min_age, output max_age, output age_span, output entries,
                  output last, input ready);
  modport sink   (input valid, input status, input rec_id, input rec_age,
                  input min_age, input max_age, input age_span, input entries,
                  input last, output ready);
endinterface
`default_nettype wire

/* rtl/age_sorted_record_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Age sorted record table
// Table of (id, age) records kept in ascending age order, with insert,
// remove, search and range commands, run by a sequencer over one memory.
// ----------------------------------------------------------------------------
// Usage: commands enter on cmd_i (mode, id, age) and results leave on rsp_o.
// Both channels move one word when valid and ready are high at a clock edge.
// Each command gives one or more result words; the final one has last set.
// Insert and the error cases give exactly one word, remove gives one word per
// removed record, search one per matching record.
//
// The block takes one command at a time. Every table read goes through the
// single read port of the record memory, whose read data is registered, so a
// visited entry takes a read state and then a check state. Insert runs a
// duplicate id scan over the table, a binary search for the slot and a shift
// of every entry above the slot. Remove and search run the binary search,
// scan the run of matching records up and down from the hit, send one word
// per record and, for remove, compact the table. A range report reads the
// first and the last entry.
//
// Reset empties the table at once (the fill count clears); the memory itself
// is not cleared. Results wait in an output register: a stalled receiver
// holds the sequencer in the state that issues the next word. cmd_i.ready
// returns as soon as the last word of a command is in the output register,
// except that a remove first compacts the table, moving each later record down.
// ----------------------------------------------------------------------------
module age_sorted_record_table_core #(
  parameter int CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  asrt_cmd_if.sink   cmd_i,
  asrt_rsp_if.source rsp_o
);
  import asrt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DUP_RD, S_DUP_CHK, S_BS_RD, S_BS_CHK, S_SH_RD, S_SH_WR,
    S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_EM_RD, S_EM_CHK,
    S_CP_RD, S_CP_WR, S_RG_LO, S_RG_HI, S_RG_CHK, S_SEND
  } state_e;

  state_e      state_q, ret_q;
  mode_e       mode_q;
  logic [31:0] key_id_q;
  logic [7:0]  key_age_q;
  logic [CW-1:0] n_q, lo_q, hp_q, mid_q, pos_q, up_q, dn_q, e_q;
  logic        down_q;
  logic [7:0]  min_q;
  rsp_t        pend_q, out_q;
  logic        out_vld_q;

  // Memory port.
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;

  // Shared compare unit and address arithmetic.
  logic          age_eq, age_gt, id_eq, out_free;
  logic [CW:0]   msum;
  logic [CW-1:0] mid_c, em1, dnm1, nm1, n_rem;

  assign age_eq   = (rdata.age == key_age_q);
  assign age_gt   = (rdata.age > key_age_q);
  assign id_eq    = (rdata.id == key_id_q);
  assign out_free = !out_vld_q || rsp_o.ready;
  assign msum     = (CW+1)'(lo_q) + (CW+1)'(hp_q) - (CW+1)'(1);
  assign mid_c    = msum[CW:1];
  assign em1      = e_q - CW'(1);
  assign dnm1     = dn_q - CW'(1);
  assign nm1      = n_q - CW'(1);
  // Fill count left after a remove: the removed run is dn_q up to up_q - 1.
  assign n_rem    = n_q - (up_q - dn_q);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = e_q[AW-1:0];
    raddr = e_q[AW-1:0];
    wdata = rdata;
    case (state_q)
      S_DUP_RD: re = (e_q != n_q);
      S_BS_RD: begin
        re    = (lo_q < hp_q);
        raddr = mid_c[AW-1:0];
      end
      S_SH_RD: begin
        if (e_q == pos_q) begin
          we       = 1'b1;
          waddr    = pos_q[AW-1:0];
          wdata.id  = key_id_q;
          wdata.age = key_age_q;
        end else begin
          re    = 1'b1;
          raddr = em1[AW-1:0];
        end
      end
      S_SH_WR: we = 1'b1;
      S_UP_RD: begin
        re    = (up_q != n_q);
        raddr = up_q[AW-1:0];
      end
      S_DN_RD: begin
        re    = (dn_q != '0);
        raddr = dnm1[AW-1:0];
      end
      S_EM_RD: re = 1'b1;
      S_CP_RD: begin
        re    = (up_q != n_q);
        raddr = up_q[AW-1:0];
      end
      S_CP_WR: begin
        we    = 1'b1;
        waddr = dn_q[AW-1:0];
      end
      S_RG_LO: begin
        re    = 1'b1;
        raddr = '0;
      end
      S_RG_HI: begin
        re    = 1'b1;
        raddr = nm1[AW-1:0];
      end
      default: ;
    endcase
  end

  asrt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      n_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // The send state reloads the output register itself.
      if (out_vld_q && rsp_o.ready && state_q != S_SEND) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            mode_q    <= mode_e'(cmd_i.mode);
            key_id_q  <= cmd_i.id;
            key_age_q <= cmd_i.age;
            e_q       <= '0;
            lo_q      <= '0;
            hp_q      <= n_q;
            case (mode_e'(cmd_i.mode))
              M_INSERT: state_q <= S_DUP_RD;
              M_RANGE: begin
                if (n_q == '0) begin
                  pend_q  <= mk_rsp(ST_EMPTY, '0, '0, '0, '0, '0, 7'(n_q), 1'b1);
                  ret_q   <= S_IDLE;
                  state_q <= S_SEND;
                end else begin
                  state_q <= S_RG_LO;
                end
              end
              default: state_q <= S_BS_RD;
            endcase
          end
        end
        S_DUP_RD: begin
          if (e_q == n_q) begin
            if (n_q == CW'(CAPACITY)) begin
              pend_q  <= mk_rsp(ST_FULL, '0, '0, '0, '0, '0, 7'(n_q), 1'b1);
              ret_q   <= S_IDLE;
              state_q <= S_SEND;
            end else begin
              state_q <= S_BS_RD;
            end
          end else begin
            state_q <= S_DUP_CHK;
          end
        end
        S_DUP_CHK: begin
          if (id_eq) begin
            pend_q  <= mk_rsp(ST_DUP, '0, '0, '0, '0, '0, 7'(n_q), 1'b1);
            ret_q   <= S_IDLE;
            state_q <= S_SEND;
          end else begin
            e_q     <= e_q + CW'(1);
            state_q <= S_DUP_RD;
          end
        end
        S_BS_RD: begin
          if (lo_q < hp_q) begin
            mid_q   <= mid_c;
            state_q <= S_BS_CHK;
          end else if (mode_q == M_INSERT) begin
            pos_q   <= lo_q;
            e_q     <= n_q;
            state_q <= S_SH_RD;
          end else begin
            pend_q  <= mk_rsp(ST_NOTFOUND, '0, '0, '0, '0, '0, 7'(n_q), 1'b1);
            ret_q   <= S_IDLE;
            state_q <= S_SEND;
          end
        end
        S_BS_CHK: begin
          if (age_eq) begin
            pos_q <= mid_q;
            up_q  <= mid_q;
            e_q   <= n_q;
            state_q <= (mode_q == M_INSERT) ? S_SH_RD : S_UP_RD;
          end else begin
            if (age_gt) begin
              hp_q <= mid_q;
            end else begin
              lo_q <= mid_q + CW'(1);
            end
            state_q <= S_BS_RD;
          end
        end
        S_SH_RD: begin
          if (e_q == pos_q) begin
            n_q     <= n_q + CW'(1);
            pend_q  <= mk_rsp(ST_OK, key_id_q, key_age_q, '0, '0, '0,
                              7'(n_q + CW'(1)), 1'b1);
            ret_q   <= S_IDLE;
            state_q <= S_SEND;
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          e_q     <= em1;
          state_q <= S_SH_RD;
        end
        S_UP_RD: begin
          if (up_q == n_q) begin
            dn_q    <= pos_q;
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_UP_CHK;
          end
        end
        S_UP_CHK: begin
          if (age_eq) begin
            up_q    <= up_q + CW'(1);
            state_q <= S_UP_RD;
          end else begin
            dn_q    <= pos_q;
            state_q <= S_DN_RD;
          end
        end
        S_DN_RD, S_DN_CHK: begin
          if (state_q == S_DN_RD && dn_q != '0) begin
            state_q <= S_DN_CHK;
          end else if (state_q == S_DN_CHK && age_eq) begin
            dn_q    <= dnm1;
            state_q <= S_DN_RD;
          end else begin
            // Search reports the run in index order; remove starts at the hit.
            e_q     <= (mode_q == M_SEARCH) ? dn_q : pos_q;
            down_q  <= 1'b0;
            state_q <= S_EM_RD;
          end
        end
        S_EM_RD: state_q <= S_EM_CHK;
        S_EM_CHK: begin
          state_q <= S_SEND;
          if (mode_q == M_SEARCH) begin
            pend_q <= mk_rsp(ST_OK, rdata.id, rdata.age, '0, '0, '0, 7'(n_q),
                             e_q == up_q - CW'(1));
            e_q    <= e_q + CW'(1);
            ret_q  <= (e_q == up_q - CW'(1)) ? S_IDLE : S_EM_RD;
          end else begin
            pend_q <= mk_rsp(ST_OK, rdata.id, rdata.age, '0, '0, '0, 7'(n_rem),
                             down_q ? (e_q == dn_q)
                                    : (e_q == up_q - CW'(1) && dn_q == pos_q));
            if (!down_q) begin
              if (e_q == up_q - CW'(1)) begin
                if (dn_q == pos_q) begin
                  ret_q <= S_CP_RD;
                end else begin
                  ret_q  <= S_EM_RD;
                  down_q <= 1'b1;
                  e_q    <= pos_q - CW'(1);
                end
              end else begin
                ret_q <= S_EM_RD;
                e_q   <= e_q + CW'(1);
              end
            end else if (e_q == dn_q) begin
              ret_q <= S_CP_RD;
            end else begin
              ret_q <= S_EM_RD;
              e_q   <= em1;
            end
          end
        end
        S_CP_RD: begin
          if (up_q == n_q) begin
            // The write pointer ends at the new fill count.
            n_q     <= dn_q;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_CP_WR;
          end
        end
        S_CP_WR: begin
          up_q    <= up_q + CW'(1);
          dn_q    <= dn_q + CW'(1);
          state_q <= S_CP_RD;
        end
        S_RG_LO: state_q <= S_RG_HI;
        S_RG_HI: begin
          min_q   <= rdata.age;
          state_q <= S_RG_CHK;
        end
        S_RG_CHK: begin
          pend_q  <= mk_rsp(ST_OK, '0, '0, min_q, rdata.age,
                            9'(rdata.age) - 9'(min_q) + 9'd1, 7'(n_q), 1'b1);
          ret_q   <= S_IDLE;
          state_q <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_q     <= pend_q;
            out_vld_q <= 1'b1;
            state_q   <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.status   = out_q.status;
  assign rsp_o.rec_id   = out_q.rec_id;
  assign rsp_o.rec_age  = out_q.rec_age;
  assign rsp_o.min_age  = out_q.min_age;
  assign rsp_o.max_age  = out_q.max_age;
  assign rsp_o.age_span = out_q.age_span;
  assign rsp_o.entries  = out_q.entries;
  assign rsp_o.last     = out_q.last;
endmodule
`default_nettype wire

/* rtl/asrt_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module asrt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  asrt_pkg::rec_t wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output asrt_pkg::rec_t rdata_o
);
  import asrt_pkg::*;

  logic [31:0] id_mem  [DEPTH];
  logic [7:0]  age_mem [DEPTH];
  rec_t        rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem[waddr_i]  <= wdata_i.id;
      age_mem[waddr_i] <= wdata_i.age;
    end
    if (re_i) begin
      rdata_q.id  <= id_mem[raddr_i];
      rdata_q.age <= age_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

/* rtl/asrt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record table checker
// Port-level checks on the command and result channels.
// ----------------------------------------------------------------------------
module asrt_chk #(
  parameter int CAPACITY = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_rec_id_i,
  input logic [6:0]  rsp_entries_i,
  input logic        rsp_last_i
);
  import asrt_pkg::*;

  // A stalled result word holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_rec_id_i) && $stable(rsp_entries_i))
    else $error("result word changed while stalled");

  // The block works on one command at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while busy");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_entries_i <= 7'(CAPACITY))
    else $error("record count beyond capacity");

  // Error words stand alone and carry no record.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_last_i && rsp_rec_id_i == '0)
    else $error("error word malformed");
endmodule

bind age_sorted_record_table_core asrt_chk #(.CAPACITY(CAPACITY)) u_asrt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_rec_id_i  (rsp_o.rec_id),
  .rsp_entries_i (rsp_o.entries),
  .rsp_last_i    (rsp_o.last)
);
`default_nettype wire

/* sim/asrt_record_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record table checker
// Watches both channels, keeps a sorted shadow table of the records and
// compares every result word with the words the shadow table predicts.
// ----------------------------------------------------------------------------
module asrt_record_checker #(
  parameter int CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  asrt_cmd_if  cmd_i,
  asrt_rsp_if  rsp_o,
  output int   fail_count_o,
  output int   pending_o
);
  import asrt_pkg::*;

  logic [31:0] shadow_id [CAPACITY];
  logic [7:0]  shadow_age[CAPACITY];
  int          shadow_fill;
  rsp_t        expected_words[$];
  int          mismatch_count;

  assign fail_count_o = mismatch_count;
  assign pending_o    = expected_words.size();

  // Binary search with the same midpoint rule as the block.
  function automatic int find_slot(logic [7:0] age, output bit hit);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_fill - 1;
    hit = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_age[mid] > age) hi = mid - 1;
      else if (shadow_age[mid] < age) lo = mid + 1;
      else begin
        hit = 1;
        return mid;
      end
    end
    return lo;
  endfunction

  function automatic rsp_t status_word(status_e st);
    return mk_rsp(st, '0, '0, '0, '0, '0, 7'(shadow_fill), 1'b1);
  endfunction

  task automatic apply_command(mode_e mode, logic [31:0] id, logic [7:0] age);
    int pos, up, dn, cnt, k;
    bit hit, dup;
    logic [31:0] gone_id[$];
    logic [7:0]  gone_age[$];
    case (mode)
      M_INSERT: begin
        dup = 0;
        for (k = 0; k < shadow_fill; k++) if (shadow_id[k] == id) dup = 1;
        if (dup) expected_words.push_back(status_word(ST_DUP));
        else if (shadow_fill >= CAPACITY) expected_words.push_back(status_word(ST_FULL));
        else begin
          pos = find_slot(age, hit);
          for (k = shadow_fill; k > pos; k--) begin
            shadow_id[k]  = shadow_id[k-1];
            shadow_age[k] = shadow_age[k-1];
          end
          shadow_id[pos]  = id;
          shadow_age[pos] = age;
          shadow_fill++;
          expected_words.push_back(mk_rsp(ST_OK, id, age, '0, '0, '0,
                                          7'(shadow_fill), 1'b1));
        end
      end
      M_REMOVE: begin
        pos = find_slot(age, hit);
        if (!hit) expected_words.push_back(status_word(ST_NOTFOUND));
        else begin
          for (up = pos; up < shadow_fill && shadow_age[up] == age; up++) begin
            gone_id.push_back(shadow_id[up]);
            gone_age.push_back(shadow_age[up]);
          end
          for (dn = pos; dn > 0 && shadow_age[dn-1] == age; dn--) begin
            gone_id.push_back(shadow_id[dn-1]);
            gone_age.push_back(shadow_age[dn-1]);
          end
          for (k = up; k < shadow_fill; k++) begin
            shadow_id[dn + k - up]  = shadow_id[k];
            shadow_age[dn + k - up] = shadow_age[k];
          end
          shadow_fill -= up - dn;
          foreach (gone_id[j])
            expected_words.push_back(mk_rsp(ST_OK, gone_id[j], gone_age[j], '0, '0, '0,
                                            7'(shadow_fill), j == gone_id.size() - 1));
        end
      end
      M_SEARCH: begin
        cnt = 0;
        for (k = 0; k < shadow_fill; k++) if (shadow_age[k] == age) cnt++;
        if (cnt == 0) expected_words.push_back(status_word(ST_NOTFOUND));
        else begin
          up = 0;
          for (k = 0; k < shadow_fill; k++)
            if (shadow_age[k] == age) begin
              up++;
              expected_words.push_back(mk_rsp(ST_OK, shadow_id[k], age, '0, '0, '0,
                                              7'(shadow_fill), up == cnt));
            end
        end
      end
      default: begin
        if (shadow_fill == 0) expected_words.push_back(status_word(ST_EMPTY));
        else expected_words.push_back(mk_rsp(ST_OK, '0, '0, shadow_age[0],
               shadow_age[shadow_fill-1],
               9'(shadow_age[shadow_fill-1]) - 9'(shadow_age[0]) + 9'd1,
               7'(shadow_fill), 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      shadow_fill    = 0;
      mismatch_count = 0;
      expected_words.delete();
    end else begin
      // Results are checked before the command of the same edge is applied;
      // the block takes one command at a time so the order cannot matter.
      if (rsp_o.valid && rsp_o.ready) begin
        got = mk_rsp(status_e'(rsp_o.status), rsp_o.rec_id, rsp_o.rec_age,
                     rsp_o.min_age, rsp_o.max_age, rsp_o.age_span,
                     rsp_o.entries, rsp_o.last);
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready)
        apply_command(mode_e'(cmd_i.mode), cmd_i.id, cmd_i.age);
    end
  end
endmodule

/* sim/tb_age_sorted_record_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record table testbench
// Drives directed and random commands in bursts while the receiver stalls,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_age_sorted_record_table_core;
  import asrt_pkg::*;

  localparam int CAPACITY = 32;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   long_hold;

  asrt_cmd_if cmd_if();
  asrt_rsp_if rsp_if();

  age_sorted_record_table_core #(.CAPACITY(CAPACITY)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_if.sink), .rsp_o(rsp_if.source)
  );

  asrt_record_checker #(.CAPACITY(CAPACITY)) checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_if), .rsp_o(rsp_if),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // A command's run time grows with the fill count and with the receiver's
  // stalls on each of its words, the long hold-off included; this watchdog
  // leaves a wide margin.
  initial begin
    #(12 * 600000);
    $display("FAILURE");
    $finish;
  end

  // The receiver stalls in its own pattern, with one long hold-off while
  // the sender keeps offering commands.
  initial begin
    int k;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        for (k = 0; k < 400; k++) @(posedge clk_i);
        long_hold = 0;
      end
      case ($urandom_range(0, 2))
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_if.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // A small pool of ages and ids makes duplicates, repeated ages and hits
  // common; a fraction is fully random to toggle every bit.
  logic [31:0] id_pool[8];

  task automatic send_word(mode_e mode, logic [31:0] id, logic [7:0] age);
    cmd_if.valid <= 1'b1;
    cmd_if.mode  <= mode;
    cmd_if.id    <= id;
    cmd_if.age   <= age;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic random_word();
    int r;
    logic [31:0] id;
    logic [7:0]  age;
    r   = $urandom_range(0, 99);
    id  = ($urandom_range(0, 3) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)] + $urandom_range(0, 40);
    age = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(20, 35));
    if (r < 45) send_word(M_INSERT, id, age);
    else if (r < 65) send_word(M_REMOVE, $urandom(), age);
    else if (r < 88) send_word(M_SEARCH, $urandom(), age);
    else send_word(M_RANGE, $urandom(), 8'($urandom()));
  endtask

  initial begin
    int n, burst;
    cmd_if.valid <= 1'b0;
    cmd_if.mode  <= M_INSERT;
    cmd_if.id    <= '0;
    cmd_if.age   <= '0;
    long_hold = 0;
    foreach (id_pool[j]) id_pool[j] = $urandom();
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Empty table: range, remove and search of an absent age.
    send_word(M_RANGE, '0, '0);
    send_word(M_REMOVE, '0, 8'd7);
    send_word(M_SEARCH, '1, 8'd7);
    // Extremes of id and age, a duplicate id, repeated ages.
    send_word(M_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_word(M_INSERT, 32'h0000_0000, 8'h00);
    send_word(M_INSERT, 32'hFFFF_FFFF, 8'h10);
    send_word(M_INSERT, 32'h5555_5555, 8'h80);
    send_word(M_INSERT, 32'hAAAA_AAAA, 8'h80);
    send_word(M_INSERT, 32'h1234_5678, 8'h80);
    send_word(M_RANGE, '0, '0);
    send_word(M_SEARCH, '0, 8'h80);
    send_word(M_SEARCH, '0, 8'h81);
    send_word(M_REMOVE, '0, 8'h80);
    send_word(M_REMOVE, '0, 8'h80);
    // Fill to capacity, overflow, then a duplicate on a full table.
    for (n = 0; n < CAPACITY; n++) send_word(M_INSERT, 32'h100 + n, 8'(n % 5));
    send_word(M_INSERT, 32'hDEAD_0001, 8'd3);
    send_word(M_INSERT, 32'h100, 8'd3);
    send_word(M_RANGE, '0, '0);
    // Long hold-off while commands keep coming: searches of many matches.
    long_hold = 1;
    send_word(M_SEARCH, '0, 8'd2);
    send_word(M_SEARCH, '0, 8'd4);
    send_word(M_REMOVE, '0, 8'd0);
    for (n = 0; n < 5; n++) send_word(M_REMOVE, '0, 8'(n));
    send_word(M_RANGE, '0, '0);

    // Random bursts with gaps between them.
    n = 0;
    while (n < 370) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_word();
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        cmd_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    cmd_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
